// ===== sv/cfre_pkg.sv =====
`default_nettype none

package cfre_pkg;

    // Widths of the request and result fields.
    localparam int unsigned OP_W    = 3;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned RIU_W   = 5;

    // Operation codes; the codes above OP_READ do nothing.
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd1;
    localparam logic [OP_W-1:0] OP_INC   = 3'd2;
    localparam logic [OP_W-1:0] OP_FRAME = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Number of registers in use after reset.
    localparam logic [RIU_W-1:0] RIU_RESET = 5'd16;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    // One register file write.
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [VALUE_W-1:0]   data;
    } rf_write_t;

endpackage

`default_nettype wire

// ===== sv/cfre_if.sv =====
`default_nettype none

// Request channel: one operation on the register file.
interface cfre_item_if;
    import cfre_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             op;
    logic [IDX_W-1:0]            target_reg;
    logic [IDX_W-1:0]            stack_reg;
    logic [VALUE_W-1:0]          byte_count;
    logic signed [VALUE_W-1:0]   displacement;
    logic signed [VALUE_W-1:0]   load_value;

    modport source (
        output valid, op, target_reg, stack_reg, byte_count, displacement, load_value,
        input  ready
    );
    modport sink (
        input  valid, op, target_reg, stack_reg, byte_count, displacement, load_value,
        output ready
    );
endinterface

// Result channel: status and resulting register value.
interface cfre_result_if;
    import cfre_pkg::*;

    logic                        valid;
    logic                        ready;
    status_t                     status;
    logic signed [VALUE_W-1:0]   result_value;

    modport source (
        output valid, status, result_value,
        input  ready
    );
    modport sink (
        input  valid, status, result_value,
        output ready
    );
endinterface

// Configuration write channel for the register count in use.
interface cfre_cfg_if;
    import cfre_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RIU_W-1:0]     registers_in_use;

    modport source (
        output valid, registers_in_use,
        input  ready
    );
    modport sink (
        input  valid, registers_in_use,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/cfre_ram.sv =====
`default_nettype none

module cfre_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; a read of the address
    // being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/checked_frame_register_executor.sv =====
// Checked frame register executor.
//
// A file of signed 64-bit registers, all zero after reset. Each request on
// the item channel loads a register, reads one back, decrements or
// increments a stack pointer register by an unsigned byte count, or sets a
// frame base register to a stack pointer plus a signed displacement. Every
// request gives exactly one response on the result channel with a status
// and the value now held by the register concerned (zero on any error).
// The cfg channel sets how many registers may be indexed; it is always ready
// and should be written only while no request is in flight.
//
// The response passes through the execute stage and the output register:
// the register file read is registered alongside the request in the execute
// stage, then the checked 66-bit add and the write-back run together into
// the output register. A request may be accepted in every cycle while the
// receiver does not stall; a write to the register read by the following
// request is forwarded. When the receiver stalls, one request waits in the
// execute stage and the item channel drops ready. Reset (rst_n, active low,
// asynchronous) empties both stages, marks every register as zero and sets
// the count in use to sixteen.
`default_nettype none

module checked_frame_register_executor #(
    parameter int unsigned NUM_REGS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cfre_item_if.sink       item,
    cfre_result_if.source   result,
    cfre_cfg_if.sink        cfg
);
    import cfre_pkg::*;

    localparam int unsigned AW = $clog2(NUM_REGS);
    localparam logic [8:0] REG_COUNT_W = 9'(NUM_REGS);

    // Register index to register file address.
    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [8:0] ext;
        ext = {5'b0, idx};
        return ext[AW-1:0];
    endfunction

    // Control and configuration state.
    logic [RIU_W-1:0]        riu_reg;
    logic                    s1_valid_reg;
    logic                    out_valid_reg;
    logic [NUM_REGS-1:0]     written_reg;

    // Execute stage payload.
    logic [OP_W-1:0]         s1_op_reg;
    logic [IDX_W-1:0]        s1_tgt_reg;
    logic [IDX_W-1:0]        s1_stk_reg;
    logic [VALUE_W-1:0]      s1_count_reg;
    logic [VALUE_W-1:0]      s1_disp_reg;
    logic [VALUE_W-1:0]      s1_load_reg;
    logic                    s1_hit_reg;
    logic                    s1_rd_valid_reg;
    logic [VALUE_W-1:0]      s1_byp_reg;

    // Output register payload.
    status_t                 out_status_reg;
    logic [VALUE_W-1:0]      out_value_reg;

    logic                    accept;
    logic                    advance;
    logic [IDX_W-1:0]        rd_idx;
    logic [VALUE_W-1:0]      ram_rdata;
    logic [VALUE_W-1:0]      operand;
    logic [8:0]              lim_eff;
    logic                    tgt_ok;
    logic                    stk_ok;
    logic [VALUE_W+1:0]      add_a;
    logic [VALUE_W+1:0]      add_b;
    logic                    add_cin;
    logic [VALUE_W+1:0]      sum;
    status_t                 range_status;
    status_t                 status_next;
    logic [VALUE_W-1:0]      value_next;
    rf_write_t               wr;

    // Handshakes: the execute stage frees up whenever the output register
    // can take its result.
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign rd_idx = (item.op == OP_READ) ? item.target_reg : item.stack_reg;

    cfre_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_REGS)
    ) u_rf (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (to_addr(wr.idx)),
        .wr_data (wr.data),
        .rd_en   (accept),
        .rd_addr (to_addr(rd_idx)),
        .rd_data (ram_rdata)
    );

    // Source operand: forwarded write, stored value, or zero if never written.
    always_comb
    begin
        if (s1_hit_reg)
        begin
            operand = s1_byp_reg;
        end
        else if (s1_rd_valid_reg)
        begin
            operand = ram_rdata;
        end
        else
        begin
            operand = '0;
        end
    end

    // Index checks against the smaller of the count in use and the file size.
    always_comb
    begin
        if ({4'b0, riu_reg} < REG_COUNT_W)
        begin
            lim_eff = {4'b0, riu_reg};
        end
        else
        begin
            lim_eff = REG_COUNT_W;
        end
        tgt_ok = ({5'b0, s1_tgt_reg} < lim_eff);
        stk_ok = ({5'b0, s1_stk_reg} < lim_eff);
    end

    // Exact 66-bit sum, then a range check against signed 64 bits.
    always_comb
    begin
        add_a   = {{2{operand[VALUE_W-1]}}, operand};
        add_b   = {{2{s1_disp_reg[VALUE_W-1]}}, s1_disp_reg};
        add_cin = 1'b0;
        if (s1_op_reg == OP_DEC)
        begin
            add_b   = ~{2'b0, s1_count_reg};
            add_cin = 1'b1;
        end
        else if (s1_op_reg == OP_INC)
        begin
            add_b = {2'b0, s1_count_reg};
        end
        sum = add_a + add_b + {{(VALUE_W+1){1'b0}}, add_cin};

        if (!sum[VALUE_W+1] && (sum[VALUE_W:VALUE_W-1] != 2'b00))
        begin
            range_status = ST_OVER;
        end
        else if (sum[VALUE_W+1] && (sum[VALUE_W:VALUE_W-1] != 2'b11))
        begin
            range_status = ST_UNDER;
        end
        else
        begin
            range_status = ST_OK;
        end
    end

    // Operation decode: status, response value and register write.
    always_comb
    begin
        status_next = ST_OK;
        value_next  = '0;
        wr.en       = 1'b0;
        wr.idx      = s1_tgt_reg;
        wr.data     = sum[VALUE_W-1:0];
        case (s1_op_reg)
            OP_LOAD:
            begin
                if (!tgt_ok)
                begin
                    status_next = ST_INDEX;
                end
                else
                begin
                    value_next = s1_load_reg;
                    wr.en      = 1'b1;
                    wr.data    = s1_load_reg;
                end
            end
            OP_DEC, OP_INC:
            begin
                wr.idx = s1_stk_reg;
                if (!stk_ok)
                begin
                    status_next = ST_INDEX;
                end
                else
                begin
                    status_next = range_status;
                    if (range_status == ST_OK)
                    begin
                        value_next = sum[VALUE_W-1:0];
                        wr.en      = 1'b1;
                    end
                end
            end
            OP_FRAME:
            begin
                if (!tgt_ok || !stk_ok)
                begin
                    status_next = ST_INDEX;
                end
                else
                begin
                    status_next = range_status;
                    if (range_status == ST_OK)
                    begin
                        value_next = sum[VALUE_W-1:0];
                        wr.en      = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (!tgt_ok)
                begin
                    status_next = ST_INDEX;
                end
                else
                begin
                    value_next = operand;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        wr.en = wr.en && advance;
    end

    // Control state: stage valids, written marks and the register count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            riu_reg       <= RIU_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                riu_reg <= cfg.registers_in_use;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr.en)
            begin
                written_reg[to_addr(wr.idx)] <= 1'b1;
            end
        end
    end

    // Execute stage payload, captured with the register file read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= item.op;
            s1_tgt_reg      <= item.target_reg;
            s1_stk_reg      <= item.stack_reg;
            s1_count_reg    <= item.byte_count;
            s1_disp_reg     <= item.displacement;
            s1_load_reg     <= item.load_value;
            s1_hit_reg      <= wr.en && (wr.idx == rd_idx);
            s1_byp_reg      <= wr.data;
            s1_rd_valid_reg <= written_reg[to_addr(rd_idx)];
        end
        if (advance)
        begin
            out_status_reg <= status_next;
            out_value_reg  <= value_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.result_value = out_value_reg;

endmodule

`default_nettype wire
